@@ src/assert_macros.svh @@
// Assertion helpers, sampled on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ src/rtrd_pkg.sv @@
package rtrd_pkg;

  // config register indexes
  localparam logic [1:0] REG_ROW_WIDTH  = 2'd0;
  localparam logic [1:0] REG_ROW_COUNT  = 2'd1;
  localparam logic [1:0] REG_TABLE_LOW  = 2'd2;
  localparam logic [1:0] REG_TABLE_HIGH = 2'd3;

  localparam logic [8:0] SIZE_MIN = 9'd1;
  localparam logic [8:0] SIZE_MAX = 9'd256;

  localparam logic [3:0] RUN_LEN_BASE = 4'd2;
  localparam logic [3:0] LEN_ONE      = 4'd1;

  // queued work item: tile, tiles to emit, byte count tag
  typedef struct packed {
    logic [7:0]  tile;
    logic [3:0]  len;
    logic [15:0] bytes;
  } item_t;

endpackage

@@ src/rtrd_front.sv @@
module rtrd_front
  import rtrd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [7:0]  code_byte,
  input  logic        q_full,
  input  logic [63:0] table_low,
  input  logic [63:0] table_high,
  output logic        push,
  output item_t       item
);

  logic [15:0] byte_cnt_r, byte_cnt_nxt;
  logic [3:0]  idx;
  logic [63:0] word;

  assign push = in_valid && !q_full;

  always_comb begin
    idx  = code_byte[6:3];
    word = idx[3] ? table_high : table_low;
    item.bytes = byte_cnt_r + 16'd1;
    if (code_byte[7]) begin
      item.tile = word[{idx[2:0], 3'b000} +: 8];
      item.len  = {1'b0, code_byte[2:0]} + RUN_LEN_BASE;
    end else begin
      item.tile = code_byte;
      item.len  = LEN_ONE;
    end
  end

  // counts every accepted byte; bytes after map end are dropped downstream
  always_comb begin
    byte_cnt_nxt = byte_cnt_r;
    if (push) begin
      byte_cnt_nxt = byte_cnt_r + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_cnt_r <= '0;
    end else begin
      byte_cnt_r <= byte_cnt_nxt;
    end
  end

endmodule

@@ src/rtrd_queue.sv @@
module rtrd_queue
  import rtrd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output logic  full,
  output logic  q_valid,
  output item_t q_item
);

  item_t      mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_pop;

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = mem_r[rd_ptr_r];
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

@@ src/rtrd_back.sv @@
module rtrd_back
  import rtrd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        pop,
  input  logic [8:0]  width_eff,
  input  logic [8:0]  height_eff,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  tile_value,
  output logic [7:0]  column,
  output logic [7:0]  row_index,
  output logic        last_of_run,
  output logic        row_end,
  output logic        map_done,
  output logic [15:0] bytes_used
);

  logic        busy_r, busy_nxt;
  logic [3:0]  rem_r, rem_nxt;
  logic [7:0]  tile_r, tile_nxt;
  logic [15:0] bytes_r, bytes_nxt;
  logic [8:0]  col_r, col_nxt;
  logic [8:0]  row_r, row_nxt;
  logic        fin_r, fin_nxt;
  logic        ov_r, ov_nxt;

  logic [7:0]  o_tile_r, o_col_r, o_row_r;
  logic        o_last_r, o_rend_r, o_done_r;
  logic [15:0] o_bytes_r;

  logic        emit, rend, done, last;
  logic [9:0]  col_inc, row_inc;

  assign pop  = !busy_r;
  assign emit = busy_r && (!ov_r || !out_stall);

  always_comb begin
    col_inc = {1'b0, col_r} + 10'd1;
    row_inc = {1'b0, row_r} + 10'd1;
    rend    = col_inc >= {1'b0, width_eff};
    done    = rend && (row_inc >= {1'b0, height_eff});
    last    = (rem_r == LEN_ONE) || rend;
  end

  always_comb begin
    busy_nxt  = busy_r;
    rem_nxt   = rem_r;
    tile_nxt  = tile_r;
    bytes_nxt = bytes_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    fin_nxt   = fin_r;
    ov_nxt    = ov_r && out_stall;
    if (emit) begin
      ov_nxt   = 1'b1;
      rem_nxt  = rem_r - 4'd1;
      busy_nxt = !last;
      if (rend) begin
        col_nxt = '0;
        row_nxt = row_inc[8:0];
        if (done) begin
          fin_nxt = 1'b1;
        end
      end else begin
        col_nxt = col_inc[8:0];
      end
    end else if (!busy_r && q_valid && !fin_r) begin
      // items popped after map end are discarded
      busy_nxt  = 1'b1;
      rem_nxt   = q_item.len;
      tile_nxt  = q_item.tile;
      bytes_nxt = q_item.bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rem_r  <= '0;
      col_r  <= '0;
      row_r  <= '0;
      fin_r  <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      rem_r  <= rem_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      fin_r  <= fin_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tile_r  <= tile_nxt;
    bytes_r <= bytes_nxt;
    if (emit) begin
      o_tile_r  <= tile_r;
      o_col_r   <= col_r[7:0];
      o_row_r   <= row_r[7:0];
      o_last_r  <= last;
      o_rend_r  <= rend;
      o_done_r  <= done;
      o_bytes_r <= bytes_r;
    end
  end

  assign out_valid   = ov_r;
  assign tile_value  = o_tile_r;
  assign column      = o_col_r;
  assign row_index   = o_row_r;
  assign last_of_run = o_last_r;
  assign row_end     = o_rend_r;
  assign map_done    = o_done_r;
  assign bytes_used  = o_bytes_r;

endmodule

@@ src/rle_tile_row_decoder.sv @@
// Run-length tile map decoder.
// Input channel (in_valid / in_stall / in_code_byte): one code byte per item.
//   A byte below 0x80 is a literal tile; a run byte picks one of 16 table
//   tiles and repeats it 2 to 9 times, cut off at the end of its row.
// Output channel (out_valid / out_stall / out_*): one tile per item with its
//   column, row, last-of-run, row-end and map-done flags and the byte count.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): row width,
//   row count and the two halves of the run table; write only while idle.
//   cfg_ready is always high.
// Throughput: while the output is not stalled the back end emits one tile per
//   cycle, with a load step before each byte; a two-entry queue in front
//   lets bytes keep arriving while a run is drained.
// Reset (synchronous, rst_n low): counters, map-done flag and queue clear;
//   size registers go to 1, the run table to zero.
// Output stall holds the output register; the back end stops, the queue
//   fills and in_stall rises. Bytes after map done are taken and dropped.
`include "assert_macros.svh"

module rle_tile_row_decoder
  import rtrd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_code_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_tile_value,
  output logic [7:0]  out_column,
  output logic [7:0]  out_row_index,
  output logic        out_last_of_run,
  output logic        out_row_end,
  output logic        out_map_done,
  output logic [15:0] out_bytes_used,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [8:0]  row_width_r, row_count_r;
  logic [63:0] table_low_r, table_high_r;
  logic [8:0]  width_eff, height_eff;

  logic  q_full, push, pop, q_valid;
  item_t push_item, q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r  <= SIZE_MIN;
      row_count_r  <= SIZE_MIN;
      table_low_r  <= '0;
      table_high_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROW_WIDTH:  row_width_r  <= cfg_data[8:0];
        REG_ROW_COUNT:  row_count_r  <= cfg_data[8:0];
        REG_TABLE_LOW:  table_low_r  <= cfg_data;
        REG_TABLE_HIGH: table_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero reads as one, anything past 256 as 256
  always_comb begin
    width_eff = row_width_r;
    if (row_width_r == '0) begin
      width_eff = SIZE_MIN;
    end else if (row_width_r > SIZE_MAX) begin
      width_eff = SIZE_MAX;
    end
    height_eff = row_count_r;
    if (row_count_r == '0) begin
      height_eff = SIZE_MIN;
    end else if (row_count_r > SIZE_MAX) begin
      height_eff = SIZE_MAX;
    end
  end

  assign in_stall = q_full;

  rtrd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .code_byte  (in_code_byte),
    .q_full     (q_full),
    .table_low  (table_low_r),
    .table_high (table_high_r),
    .push       (push),
    .item       (push_item)
  );

  rtrd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  rtrd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .pop         (pop),
    .width_eff   (width_eff),
    .height_eff  (height_eff),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .tile_value  (out_tile_value),
    .column      (out_column),
    .row_index   (out_row_index),
    .last_of_run (out_last_of_run),
    .row_end     (out_row_end),
    .map_done    (out_map_done),
    .bytes_used  (out_bytes_used)
  );

  // a row end always closes the run
  `ASSERT_IMPL(a_rend_last, out_valid && out_row_end, out_last_of_run)
  // map done only on a row end
  `ASSERT_IMPL(a_done_rend, out_valid && out_map_done, out_row_end)
  // nothing follows the final tile once it is taken
  `ASSERT_NEXT(a_done_quiet, out_valid && !out_stall && out_map_done, !out_valid)

endmodule
